// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define PCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset
`define PCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/pcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

   // Run storage depth and the widths that follow from it
   localparam int RUN_DEPTH  = 32;
   localparam int RUN_ADDR_W = $clog2(RUN_DEPTH);
   localparam int RUN_CNT_W  = $clog2(RUN_DEPTH + 1);

   // Printable ASCII window
   localparam logic [7:0] ASCII_LO = 8'h20;
   localparam logic [7:0] ASCII_HI = 8'h7E;

   // Letters whose form also depends on the previous byte
   localparam logic [7:0] CH_EIN   = 8'd218;
   localparam logic [7:0] CH_GHEIN = 8'd219;
   localparam logic [7:0] CH_HE    = 8'd229;
   localparam logic [7:0] CH_ALEF  = 8'd199;
   localparam logic [7:0] CH_YE    = 8'd237;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLUSH_RD,
      ST_FLUSH_PUSH,
      ST_STORE,
      ST_PUSH,
      ST_FINAL
   } seq_state_type;

   // One word handed from the sequencer to the shaper
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       split;
      logic       close;
   } push_type;

   // Run memory access
   typedef struct packed {
      logic                  wr_en;
      logic [RUN_ADDR_W-1:0] wr_addr;
      logic [7:0]            wr_data;
      logic                  rd_en;
      logic [RUN_ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] iso_code;
      logic [7:0] join_code;
   } letter_type;

   function automatic letter_type letter_lookup(input logic [7:0] b);
      letter_type r;
      unique case (b)
         8'hC2: r = '{1'b1, 8'h8D, 8'h8D};
         8'hC8: r = '{1'b1, 8'h92, 8'h93};
         8'h81: r = '{1'b1, 8'h94, 8'h95};
         8'hCA: r = '{1'b1, 8'h96, 8'h97};
         8'hCB: r = '{1'b1, 8'h98, 8'h99};
         8'hCC: r = '{1'b1, 8'h9A, 8'h9B};
         8'h8D: r = '{1'b1, 8'h9C, 8'h9D};
         8'hCD: r = '{1'b1, 8'h9E, 8'h9F};
         8'hCE: r = '{1'b1, 8'hA0, 8'hA1};
         8'hCF: r = '{1'b1, 8'hA2, 8'hA2};
         8'hD0: r = '{1'b1, 8'hA3, 8'hA3};
         8'hD1: r = '{1'b1, 8'hA4, 8'hA4};
         8'hD2: r = '{1'b1, 8'hA5, 8'hA5};
         8'h8E: r = '{1'b1, 8'hA6, 8'hA6};
         8'hD3: r = '{1'b1, 8'hA7, 8'hA8};
         8'hD4: r = '{1'b1, 8'hA9, 8'hAA};
         8'hD5: r = '{1'b1, 8'hAB, 8'hAC};
         8'hD6: r = '{1'b1, 8'hAD, 8'hAE};
         8'hD8: r = '{1'b1, 8'hAF, 8'hAF};
         8'hD9: r = '{1'b1, 8'hE0, 8'hE0};
         8'hDD: r = '{1'b1, 8'hE9, 8'hEA};
         8'hDE: r = '{1'b1, 8'hEB, 8'hEC};
         8'h98: r = '{1'b1, 8'hED, 8'hEE};
         8'h90: r = '{1'b1, 8'hEF, 8'hF0};
         8'hE1: r = '{1'b1, 8'hF1, 8'hF3};
         8'hE3: r = '{1'b1, 8'hF4, 8'hF5};
         8'hE4: r = '{1'b1, 8'hF6, 8'hF7};
         8'hE6: r = '{1'b1, 8'hF8, 8'hF8};
         8'h80: r = '{1'b1, 8'h80, 8'h80};
         8'h8A: r = '{1'b1, 8'h81, 8'h81};
         8'h82: r = '{1'b1, 8'h82, 8'h82};
         8'h83: r = '{1'b1, 8'h83, 8'h83};
         8'h84: r = '{1'b1, 8'h84, 8'h84};
         8'h85: r = '{1'b1, 8'h85, 8'h85};
         8'h86: r = '{1'b1, 8'h86, 8'h86};
         8'h87: r = '{1'b1, 8'h87, 8'h87};
         8'h88: r = '{1'b1, 8'h88, 8'h88};
         8'h89: r = '{1'b1, 8'h89, 8'h89};
         8'h20: r = '{1'b1, 8'h20, 8'h20};
         8'hA1: r = '{1'b1, 8'h8A, 8'h8A};
         8'hC1: r = '{1'b1, 8'h8F, 8'h8E};
         default: r = '{1'b0, 8'h00, 8'h00};
      endcase
      return r;
   endfunction

   // Bytes that connect to the letter before them
   function automatic logic joins_before(input logic [7:0] b);
      logic r;
      case (b) inside
         8'hC2, 8'hC7, 8'hC8, 8'h81, 8'hCA, 8'hCB, 8'hCC, 8'h8D, 8'hCD, 8'hCE,
         8'hCF, 8'hD0, 8'hD1, 8'hD2, 8'h8E, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hD8,
         8'hD9, 8'hDD, 8'hDE, 8'h98, 8'h90, 8'hE1, 8'hE3, 8'hE4, 8'hE6, 8'hDA,
         8'hDB, 8'hED, 8'hE5, 8'hC1: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // Bytes that connect to the letter after them
   function automatic logic joins_after(input logic [7:0] b);
      logic r;
      case (b) inside
         8'hC8, 8'h81, 8'hCA, 8'hCB, 8'hCC, 8'h8D, 8'hCD, 8'hCE, 8'hD3, 8'hD4,
         8'hD5, 8'hD6, 8'hD8, 8'hD9, 8'hDA, 8'hDB, 8'hDD, 8'hDE, 8'h98, 8'h90,
         8'hE1, 8'hE3, 8'hE4, 8'hE5, 8'hED, 8'hC1: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] shape_byte(input logic [7:0] cur,
                                             input logic [7:0] prev,
                                             input logic [7:0] next);
      logic       jn;
      logic       jp;
      letter_type lt;
      logic [7:0] r;
      jn = joins_before(next);
      jp = joins_after(prev);
      lt = letter_lookup(cur);
      if (lt.hit) begin
         r = jn ? lt.join_code : lt.iso_code;
      end else begin
         unique case (cur)
            CH_EIN:   r = jn ? (jp ? 8'd227 : 8'd228) : (jp ? 8'd226 : 8'd225);
            CH_GHEIN: r = jn ? (jp ? 8'd231 : 8'd232) : (jp ? 8'd230 : 8'd229);
            CH_HE:    r = jn ? (jp ? 8'd250 : 8'd251) : 8'd249;
            CH_ALEF:  r = jp ? 8'd145 : 8'd144;
            CH_YE:    r = jn ? 8'd254 : (jp ? 8'd252 : 8'd253);
            default:  r = cur;
         endcase
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/pcs_run_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcs_run_mem (
   input  wire logic                clock,
   input  wire pcs_pkg::mem_req_type mem_req,
   output logic [7:0]               rd_data
);
   import pcs_pkg::*;

   logic [7:0] mem [RUN_DEPTH];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Registered read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/pcs_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pcs_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,
   input  wire logic                 req_tlast,
   input  wire logic                 csr_we,
   input  wire logic                 csr_wdata,
   output pcs_pkg::push_type         cmd,
   input  wire logic                 cmd_ready,
   output pcs_pkg::mem_req_type      mem_req,
   input  wire logic [7:0]           rd_data
);
   import pcs_pkg::*;

   seq_state_type        state_ff, state_in;
   logic [RUN_CNT_W-1:0] count_ff, count_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 split_ff, split_in;
   logic                 store_pend_ff, store_pend_in;
   logic                 push_pend_ff, push_pend_in;
   logic                 last_pend_ff, last_pend_in;
   logic                 rev_ff, rev_in;

   logic                 printable;
   logic                 store_mode;
   logic                 need_flush;
   logic [RUN_CNT_W-1:0] count_dec;
   seq_state_type        after_flush;

   assign printable  = (req_tdata >= ASCII_LO) && (req_tdata <= ASCII_HI);
   assign store_mode = rev_ff && printable;
   assign need_flush = store_mode ? (count_ff == RUN_CNT_W'(RUN_DEPTH))
                                  : (count_ff != '0);
   assign count_dec  = count_ff - 1'b1;

   // Pick the step that follows a finished flush
   always_comb begin
      if (store_pend_ff) begin
         after_flush = ST_STORE;
      end else if (push_pend_ff) begin
         after_flush = ST_PUSH;
      end else if (last_pend_ff) begin
         after_flush = ST_FINAL;
      end else begin
         after_flush = ST_IDLE;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (need_flush) begin
                  state_in = ST_FLUSH_RD;
               end else if (store_mode) begin
                  state_in = ST_STORE;
               end else begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_FLUSH_RD: state_in = ST_FLUSH_PUSH;
         ST_FLUSH_PUSH: begin
            if (cmd_ready) begin
               state_in = (count_ff != '0) ? ST_FLUSH_RD : after_flush;
            end
         end
         ST_STORE: state_in = last_pend_ff ? ST_FLUSH_RD : ST_IDLE;
         ST_PUSH: begin
            if (cmd_ready) begin
               state_in = last_pend_ff ? ST_FINAL : ST_IDLE;
            end
         end
         ST_FINAL: begin
            if (cmd_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: handshake, memory access and shaper word
   always_comb begin
      req_tready      = (state_ff == ST_IDLE);
      mem_req         = '0;
      cmd             = '0;
      unique case (state_ff)
         ST_STORE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = count_ff[RUN_ADDR_W-1:0];
            mem_req.wr_data = byte_ff;
         end
         ST_FLUSH_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = count_dec[RUN_ADDR_W-1:0];
         end
         ST_FLUSH_PUSH: begin
            cmd.valid = 1'b1;
            cmd.data  = rd_data;
            cmd.split = split_ff;
         end
         ST_PUSH: begin
            cmd.valid = 1'b1;
            cmd.data  = byte_ff;
         end
         ST_FINAL: begin
            cmd.valid = 1'b1;
            cmd.close = 1'b1;
         end
         default: ;
      endcase
   end

   // Datapath and pending-step flags
   always_comb begin
      count_in      = count_ff;
      byte_in       = byte_ff;
      split_in      = split_ff;
      store_pend_in = store_pend_ff;
      push_pend_in  = push_pend_ff;
      last_pend_in  = last_pend_ff;
      rev_in        = csr_we ? csr_wdata : rev_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               byte_in       = req_tdata;
               last_pend_in  = req_tlast;
               store_pend_in = store_mode;
               push_pend_in  = !store_mode;
               split_in      = store_mode;
            end
         end
         ST_FLUSH_RD: count_in = count_dec;
         ST_STORE: begin
            count_in      = count_ff + 1'b1;
            store_pend_in = 1'b0;
            if (last_pend_ff) begin
               split_in = 1'b0;
            end
         end
         ST_PUSH: begin
            if (cmd_ready) begin
               push_pend_in = 1'b0;
            end
         end
         ST_FINAL: begin
            if (cmd_ready) begin
               last_pend_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         split_ff      <= 1'b0;
         store_pend_ff <= 1'b0;
         push_pend_ff  <= 1'b0;
         last_pend_ff  <= 1'b0;
         rev_ff        <= 1'b1;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         split_ff      <= split_in;
         store_pend_ff <= store_pend_in;
         push_pend_ff  <= push_pend_in;
         last_pend_ff  <= last_pend_in;
         rev_ff        <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   `PCS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= RUN_CNT_W'(RUN_DEPTH), "run count above depth")
   `PCS_ASSERT_NOW(a_flush_nonempty, clock, reset, state_ff == ST_FLUSH_RD, count_ff != '0, "flush read with empty run")
   `PCS_ASSERT_NEXT(a_store_count, clock, reset, state_ff == ST_STORE, count_ff == RUN_CNT_W'($past(count_ff) + 1'b1), "store did not advance run count")

endmodule

`default_nettype wire

// ===== sv/pcs_shaper.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pcs_shaper (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pcs_pkg::push_type cmd,
   output logic                   cmd_ready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser
);
   import pcs_pkg::*;

   logic [7:0] held_ff, held_in;
   logic       held_valid_ff, held_valid_in;
   logic [7:0] before_ff, before_in;
   logic       held_split_ff, held_split_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_split_ff, rsp_split_in;

   logic       slot_free;
   logic       fire;
   logic       emit;
   logic [7:0] next_byte;

   // A held byte leaves only when the output register can take it
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign cmd_ready = !held_valid_ff || slot_free;
   assign fire      = cmd.valid && cmd_ready;
   assign emit      = fire && held_valid_ff;
   assign next_byte = cmd.close ? 8'h00 : cmd.data;

   // Output register: load on emit, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_split_in = rsp_split_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = shape_byte(held_ff, before_ff, next_byte);
         rsp_last_in  = cmd.close;
         rsp_split_in = held_split_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Held byte and its predecessor
   always_comb begin
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      before_in     = before_ff;
      held_split_in = held_split_ff;
      if (fire) begin
         if (cmd.close) begin
            held_in       = 8'h00;
            held_valid_in = 1'b0;
            before_in     = 8'h00;
            held_split_in = 1'b0;
         end else begin
            if (held_valid_ff) begin
               before_in = held_ff;
            end
            held_in       = cmd.data;
            held_valid_in = 1'b1;
            held_split_in = cmd.split;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= 8'h00;
         held_valid_ff <= 1'b0;
         before_ff     <= 8'h00;
         held_split_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         before_ff     <= before_in;
         held_split_ff <= held_split_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_split_ff <= rsp_split_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_split_ff;

   `PCS_ASSERT_NEXT(a_close_clears, clock, reset, fire && cmd.close, !held_valid_ff && (before_ff == 8'h00), "string end left context behind")

endmodule

`default_nettype wire

// ===== sv/persian_contextual_shaper_top.sv =====
// Persian contextual shaper: Windows-1256 text bytes in, Persian DOS code
// page bytes out, shaped by their neighbors.
// Input channel req_*: one text byte per word, req_tlast on the last byte of
// a string. Output channel rsp_*: one shaped byte per word, rsp_tlast on the
// last byte of the string, rsp_tuser set for bytes of a run flushed early
// because the run memory was full.
// csr_we/csr_wdata write reverse_runs (reset 1); write only while idle.
// A byte may flush run bytes first (a full run, or a run closed by a byte that
// is not stored); a string end flushes the run and adds a closing word.
// Each flushed byte is read from the registered run memory, then handed on.
// req_tready is high only while idle, so a new byte waits for the last to finish.
// Output: a byte is shown once its successor (or string end) is known, in the
// cycle after the shaper takes that successor.
// Reset: clears the run count, the held byte and the output register;
// the run memory needs no clearing since only stored entries are read.
// Stall: the output register holds its word while rsp_tready is low; one
// more byte may move into the shaper, then the sequencer waits with its
// word and req_tready stays low. Printable bytes still go into the run
// memory until one of them needs a flush.
`timescale 1ns / 1ps
`default_nettype none

module persian_contextual_shaper_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast,
   output logic            rsp_tuser,   // [0] run_split
   input  wire logic       csr_we,
   input  wire logic       csr_wdata
);
   import pcs_pkg::*;

   push_type    cmd;
   logic        cmd_ready;
   mem_req_type mem_req;
   logic [7:0]  rd_data;

   pcs_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .cmd_ready  (cmd_ready),
      .mem_req    (mem_req),
      .rd_data    (rd_data)
   );

   pcs_run_mem u_run_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   pcs_shaper u_shaper (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cmd_ready  (cmd_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

import pcs_pkg::*;

// One shaped byte as it should leave the block
typedef struct packed {
   logic [7:0] code;
   logic       last;
   logic       split;
} shaped_word_type;

// Shapes the accepted text bytes on its own and checks what the block sends
class shaper_scoreboard;
   bit              reverse_on = 1'b1;
   logic [7:0]      run_mem [RUN_DEPTH];
   int              run_len = 0;
   logic [7:0]      held_b = '0;
   bit              held_v = 1'b0;
   bit              held_split = 1'b0;
   logic [7:0]      prev_b = '0;
   shaped_word_type shaped_q [$];
   int              n_words = 0;
   int              n_checked = 0;
   int              n_split = 0;
   int              n_fail = 0;

   // Bytes that connect to the letter in front of them
   function bit links_back(logic [7:0] b);
      case (b)
         8'hC2, 8'hC7, 8'hC8, 8'h81, 8'hCA, 8'hCB, 8'hCC, 8'h8D, 8'hCD, 8'hCE,
         8'hCF, 8'hD0, 8'hD1, 8'hD2, 8'h8E, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hD8,
         8'hD9, 8'hDD, 8'hDE, 8'h98, 8'h90, 8'hE1, 8'hE3, 8'hE4, 8'hE6, 8'hDA,
         8'hDB, 8'hED, 8'hE5, 8'hC1: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Bytes that connect to the letter after them
   function bit links_fwd(logic [7:0] b);
      case (b)
         8'hC8, 8'h81, 8'hCA, 8'hCB, 8'hCC, 8'h8D, 8'hCD, 8'hCE, 8'hD3, 8'hD4,
         8'hD5, 8'hD6, 8'hD8, 8'hD9, 8'hDA, 8'hDB, 8'hDD, 8'hDE, 8'h98, 8'h90,
         8'hE1, 8'hE3, 8'hE4, 8'hE5, 8'hED, 8'hC1: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Isolated and joined codes of the plain letters
   function bit base_forms(input logic [7:0] b, output logic [7:0] iso,
                           output logic [7:0] joined);
      bit hit;
      hit = 1'b1;
      case (b)
         8'hC2: {iso, joined} = 16'h8D8D;
         8'hC8: {iso, joined} = 16'h9293;
         8'h81: {iso, joined} = 16'h9495;
         8'hCA: {iso, joined} = 16'h9697;
         8'hCB: {iso, joined} = 16'h9899;
         8'hCC: {iso, joined} = 16'h9A9B;
         8'h8D: {iso, joined} = 16'h9C9D;
         8'hCD: {iso, joined} = 16'h9E9F;
         8'hCE: {iso, joined} = 16'hA0A1;
         8'hCF: {iso, joined} = 16'hA2A2;
         8'hD0: {iso, joined} = 16'hA3A3;
         8'hD1: {iso, joined} = 16'hA4A4;
         8'hD2: {iso, joined} = 16'hA5A5;
         8'h8E: {iso, joined} = 16'hA6A6;
         8'hD3: {iso, joined} = 16'hA7A8;
         8'hD4: {iso, joined} = 16'hA9AA;
         8'hD5: {iso, joined} = 16'hABAC;
         8'hD6: {iso, joined} = 16'hADAE;
         8'hD8: {iso, joined} = 16'hAFAF;
         8'hD9: {iso, joined} = 16'hE0E0;
         8'hDD: {iso, joined} = 16'hE9EA;
         8'hDE: {iso, joined} = 16'hEBEC;
         8'h98: {iso, joined} = 16'hEDEE;
         8'h90: {iso, joined} = 16'hEFF0;
         8'hE1: {iso, joined} = 16'hF1F3;
         8'hE3: {iso, joined} = 16'hF4F5;
         8'hE4: {iso, joined} = 16'hF6F7;
         8'hE6: {iso, joined} = 16'hF8F8;
         8'h8A: {iso, joined} = 16'h8181;
         8'hA1: {iso, joined} = 16'h8A8A;
         8'hC1: {iso, joined} = 16'h8F8E;
         8'h80, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h20:
            {iso, joined} = {b, b};
         default: begin
            hit = 1'b0;
            {iso, joined} = '0;
         end
      endcase
      return hit;
   endfunction

   // Pick the form of a byte from its neighbors
   function logic [7:0] form_of(logic [7:0] cur, logic [7:0] prev, logic [7:0] nxt);
      logic [7:0] iso;
      logic [7:0] joined;
      bit         jn;
      bit         jp;
      jn = links_back(nxt);
      jp = links_fwd(prev);
      if (base_forms(cur, iso, joined)) return jn ? joined : iso;
      case (cur)
         CH_EIN:   return jn ? (jp ? 8'd227 : 8'd228) : (jp ? 8'd226 : 8'd225);
         CH_GHEIN: return jn ? (jp ? 8'd231 : 8'd232) : (jp ? 8'd230 : 8'd229);
         CH_HE:    return jn ? (jp ? 8'd250 : 8'd251) : 8'd249;
         CH_ALEF:  return jp ? 8'd145 : 8'd144;
         CH_YE:    return jn ? 8'd254 : (jp ? 8'd252 : 8'd253);
         default:  return cur;
      endcase
   endfunction

   function void set_reverse(bit v);
      reverse_on = v;
   endfunction

   // Hand a byte to the shaping stage; the held byte goes out once its successor is known
   function void hand_on(logic [7:0] b, bit split);
      if (held_v) begin
         shaped_q.push_back(shaped_word_type'{form_of(held_b, prev_b, b), 1'b0, held_split});
         prev_b = held_b;
      end
      held_b     = b;
      held_split = split;
      held_v     = 1'b1;
   endfunction

   // Drain the pending run, newest byte first
   function void flush_run(bit split);
      while (run_len > 0) begin
         run_len--;
         hand_on(run_mem[run_len], split);
      end
   endfunction

   // Note one accepted text byte and queue the shaped bytes it releases
   function void note_word(logic [7:0] b, logic last);
      bit printable;
      printable = (b >= ASCII_LO) && (b <= ASCII_HI);
      n_words++;
      if (reverse_on && printable) begin
         if (run_len >= RUN_DEPTH) flush_run(1'b1);
         run_mem[run_len] = b;
         run_len++;
      end else begin
         flush_run(1'b0);
         hand_on(b, 1'b0);
      end
      if (last) begin
         flush_run(1'b0);
         if (held_v) shaped_q.push_back(shaped_word_type'{form_of(held_b, prev_b, 8'h00),
                                                          1'b1, held_split});
         held_v     = 1'b0;
         held_b     = '0;
         held_split = 1'b0;
         prev_b     = '0;
      end
   endfunction

   function void report(string what);
      n_fail++;
      if (n_fail <= 10) $display("%0t: %s", $time, what);
   endfunction

   // Compare one shaped byte from the block with the oldest expectation
   function void check_word(logic [7:0] code, logic last, logic split);
      shaped_word_type want;
      n_checked++;
      if (split === 1'b1) n_split++;
      if (shaped_q.size() == 0) begin
         report($sformatf("unexpected word: byte %02h last %0b split %0b",
                          code, last, split));
         return;
      end
      want = shaped_q.pop_front();
      if (want.code !== code || want.last !== last || want.split !== split)
         report($sformatf({"mismatch: expected byte %02h last %0b split %0b, ",
                           "got byte %02h last %0b split %0b"},
                          want.code, want.last, want.split, code, last, split));
   endfunction

   function int pending();
      return shaped_q.size();
   endfunction

   // Count what never arrived
   function void close_out();
      if (shaped_q.size() != 0) begin
         n_fail += shaped_q.size();
         $display("%0t: %0d expected words never arrived", $time, shaped_q.size());
      end
   endfunction
endclass

module tb_top;
   localparam int HOLD_CYCLES = 300;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       rsp_tuser;
   logic       csr_we = 1'b0;
   logic       csr_wdata = 1'b0;

   shaper_scoreboard sb;
   bit               gaps_on = 1'b1;
   bit               hold_req = 1'b0;
   int               sent = 0;
   logic [7:0]       text_q [$];

   // Letters, including the ones that look at both neighbors
   logic [7:0] persian_pool [45] = '{
      8'hC2, 8'hC8, 8'h81, 8'hCA, 8'hCB, 8'hCC, 8'h8D, 8'hCD, 8'hCE, 8'hCF,
      8'hD0, 8'hD1, 8'hD2, 8'h8E, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hD8, 8'hD9,
      8'hDD, 8'hDE, 8'h98, 8'h90, 8'hE1, 8'hE3, 8'hE4, 8'hE6, 8'h80, 8'h8A,
      8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'hA1, 8'hC1,
      8'hC7, 8'hDA, 8'hDB, 8'hE5, 8'hED
   };

   always #6 clock = ~clock;

   persian_contextual_shaper_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Offer one text byte, idling at random first, and hold it until taken
   task automatic send_word(input logic [7:0] b, input logic last);
      while (gaps_on && $urandom_range(0, 99) < 17) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_word(b, last);
      sent++;
   endtask

   // Send the queued text, the last byte closing the string when asked
   task automatic send_text(input bit close);
      foreach (text_q[i]) send_word(text_q[i], close && (i == text_q.size() - 1));
      text_q.delete();
   endtask

   // Stop offering and wait until every shaped byte is back
   task automatic drain_all();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reverse(input bit v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reverse(v);
   endtask

   // Build a string of Persian words, printable runs and noise bytes
   task automatic make_text();
      int tokens;
      int kind;
      int len;
      tokens = $urandom_range(1, 6);
      repeat (tokens) begin
         kind = $urandom_range(0, 9);
         len  = $urandom_range(1, 6);
         repeat (len) begin
            if (kind < 5)
               text_q.push_back(persian_pool[$urandom_range(0, $size(persian_pool) - 1)]);
            else if (kind < 8)
               text_q.push_back(8'($urandom_range(ASCII_LO, ASCII_HI)));
            else
               text_q.push_back(8'($urandom_range(1, 255)));
         end
      end
   endtask

   // Result side: check accepted words, then pick the next ready
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_word(rsp_tdata, rsp_tlast, rsp_tuser);
         if (hold_left == 0 && hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !gaps_on || ($urandom_range(0, 99) >= 17);
         end
      end
   end

   initial begin : watchdog
      #4_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin : stim
      int mark;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Contextual letters at string start, inside words and before noise bytes
      text_q = '{8'hC7, 8'hDA, 8'hDB, 8'hE5, 8'hC7, "A", "B", "C", 8'hE1, "x",
                 8'hED, 8'h01, 8'hFF};
      send_text(1'b1);
      // Lone ein as a whole string
      text_q = '{8'hDA};
      send_text(1'b1);
      // Printable run closed by the string end
      text_q = '{8'hED, 8'hDB, "Z", 8'h7E, 8'h20};
      send_text(1'b1);
      text_q = '{8'h80, 8'hE5, 8'hE5, 8'hC8};
      send_text(1'b1);

      // Leave a run pending, turn reversal off, then continue the string
      text_q = '{"p", "q"};
      send_text(1'b0);
      drain_all();
      write_reverse(1'b0);
      text_q = '{8'hC8, "r", "s", 8'hE5};
      send_text(1'b1);

      // Random strings in source order, most of them without idling
      mark = sent;
      while (sent - mark < 20) begin
         if (sent - mark >= 6) gaps_on = 1'b0;
         make_text();
         send_text(1'b1);
      end
      gaps_on = 1'b1;
      drain_all();
      write_reverse(1'b1);

      // Long printable string against a stalled receiver: storage fills once
      hold_req = 1'b1;
      repeat (34) text_q.push_back(8'($urandom_range(ASCII_LO, ASCII_HI)));
      send_text(1'b1);

      // Random strings with reversal, pausing between some for everything to return
      mark = sent;
      while (sent - mark < 16) begin
         make_text();
         send_text(1'b1);
         if (sent - mark >= 6 && sent - mark < 12) drain_all();
      end
      drain_all();
      sb.close_out();

      $display("tb_top: %0d text bytes in, %0d shaped bytes checked, %0d from early flushes",
               sb.n_words, sb.n_checked, sb.n_split);
      $display("tb_top: reversal on, off and on again; one receiver hold-off of %0d cycles",
               HOLD_CYCLES);
      if (sb.n_fail == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: %0d failures", sb.n_fail);
         $display("tb_top: FAIL");
      end
      $finish;
   end
endmodule
